// ----- hw/rtl/pws_pkg.sv -----
// Shared types, codes and defaults for the paced register write sequencer.
`timescale 1ns / 1ps

package pws_pkg;

    localparam int CLOCK_DIVIDE_DEFAULT = 4;
    localparam int COUNT_WIDTH_DEFAULT  = 32;

    localparam logic [7:0] WAIT_ADDRESS_RESET = 8'd12;
    localparam logic [7:0] WAIT_DATA_RESET    = 8'd84;
    localparam logic [7:0] DATA_IDLE          = 8'h00;

    // configuration register indexes
    localparam logic REG_WAIT_AFTER_ADDRESS = 1'b0;
    localparam logic REG_WAIT_AFTER_DATA    = 1'b1;

    // input opcodes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_ADDR  = 2'd1;
    localparam logic [1:0] OP_DATA  = 2'd2;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_ADDR = 2'd1,
        KIND_DATA = 2'd2
    } prev_kind_t;

    typedef enum logic [3:0] {
        STEP_IDLE    = 4'd0,
        STEP_WAIT    = 4'd1,
        STEP_SET_A0  = 4'd2,
        STEP_CS_LOW  = 4'd3,
        STEP_SET_D   = 4'd4,
        STEP_WR_LOW  = 4'd5,
        STEP_HOLD    = 4'd6,
        STEP_RELEASE = 4'd7,
        STEP_CLEAR_D = 4'd8
    } step_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] byte_value;
    } in_item_t;

    typedef struct packed {
        logic       address_select;
        logic       chip_select_n;
        logic       write_strobe_n;
        logic [7:0] data_bus;
        logic       master_phase;
        logic       busy_res;
        logic       request_accepted;
    } out_item_t;

endpackage

// ----- hw/rtl/pws_stream_if.sv -----
// Valid/ready stream channel with a typed payload.
`timescale 1ns / 1ps

interface pws_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/paced_register_write_sequencer.sv -----
// Paced register write sequencer: clock divider, write pacing and pin sequencing.
`timescale 1ns / 1ps

// Usage:
//   req carries items of opcode and byte_value: a tick advances the divided
//   master clock by one step, an address or data opcode asks for a register
//   write. res returns exactly one item per req transfer: the pin levels,
//   the master clock level, a busy flag and whether a write request was taken.
//   A write request made while busy is refused (request_accepted low).
//   cfg_we/cfg_index/cfg_data set the spacing, in master cycles, that must pass
//   after an address write or a data write before the next write begins.
//   The result of a transfer is registered and is valid in the cycle after it.
//   Throughput: one item per cycle; all state updates for an item are done
//   in the cycle it transfers, ahead of a single result register.
//   When the receiver stalls, the result register holds and req stays ready
//   while the result can leave in the same cycle; otherwise req waits.
//   Reset clears the divider, counts and sequencer, drives CS_n and WR_n high,
//   A0 and D low, and loads the spacing defaults of 12 and 84.
module paced_register_write_sequencer
    import pws_pkg::*;
#(
    parameter int CLOCK_DIVIDE = CLOCK_DIVIDE_DEFAULT,
    parameter int COUNT_WIDTH  = COUNT_WIDTH_DEFAULT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    pws_stream_if.sink               req,
    pws_stream_if.source             res,
    input  logic                     cfg_we,
    input  logic                     cfg_index,
    input  logic [7:0]               cfg_data
);

    localparam int DIV_W = (CLOCK_DIVIDE > 2) ? $clog2(CLOCK_DIVIDE) : 1;
    localparam logic [DIV_W-1:0] DIV_LAST = DIV_W'(CLOCK_DIVIDE - 1);

    logic [7:0]             wait_addr_reg;
    logic [7:0]             wait_data_reg;

    logic [DIV_W-1:0]       phase_reg, phase_next;
    logic                   level_reg, level_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    prev_kind_t             prev_kind_reg, prev_kind_next;
    logic [COUNT_WIDTH-1:0] prev_count_reg, prev_count_next;
    logic [7:0]             wait_left_reg, wait_left_next;
    step_t                  step_reg, step_next;
    logic                   pend_kind_reg, pend_kind_next;
    logic [7:0]             pend_byte_reg, pend_byte_next;
    logic                   a0_reg, a0_next;
    logic                   cs_n_reg, cs_n_next;
    logic                   wr_n_reg, wr_n_next;
    logic [7:0]             data_reg, data_next;

    logic                   accepted;
    logic                   rise;
    logic                   fall;
    logic [7:0]             need;
    logic [COUNT_WIDTH-1:0] diff;
    logic [7:0]             wait_dec;

    logic                   out_valid_reg;
    out_item_t              out_item_reg;
    out_item_t              out_item;
    logic                   in_fire;

    assign req.ready   = !out_valid_reg || res.ready;
    assign in_fire     = req.valid && req.ready;
    assign res.valid   = out_valid_reg;
    assign res.payload = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wait_addr_reg <= WAIT_ADDRESS_RESET;
            wait_data_reg <= WAIT_DATA_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WAIT_AFTER_ADDRESS: wait_addr_reg <= cfg_data;
                REG_WAIT_AFTER_DATA:    wait_data_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // spacing needed since the previous write, and master cycles elapsed
    always_comb
    begin
        unique case (prev_kind_reg)
            KIND_ADDR: need = wait_addr_reg;
            KIND_DATA: need = wait_data_reg;
            default:   need = 8'd0;
        endcase
    end

    assign diff     = count_reg - prev_count_reg;
    assign wait_dec = (wait_left_reg != 8'd0) ? wait_left_reg - 8'd1 : 8'd0;

    // next state for one transferred item
    always_comb
    begin
        phase_next      = phase_reg;
        level_next      = level_reg;
        count_next      = count_reg;
        prev_kind_next  = prev_kind_reg;
        prev_count_next = prev_count_reg;
        wait_left_next  = wait_left_reg;
        step_next       = step_reg;
        pend_kind_next  = pend_kind_reg;
        pend_byte_next  = pend_byte_reg;
        a0_next         = a0_reg;
        cs_n_next       = cs_n_reg;
        wr_n_next       = wr_n_reg;
        data_next       = data_reg;
        accepted        = 1'b0;
        rise            = 1'b0;
        fall            = 1'b0;

        if (in_fire)
        begin
            unique case (req.payload.opcode) inside
                OP_TICK:
                begin
                    if (phase_reg >= DIV_LAST)
                    begin
                        phase_next = '0;
                        level_next = 1'b1;
                    end
                    else
                    begin
                        phase_next = phase_reg + 1'b1;
                        if (phase_reg == '0)
                        begin
                            level_next = 1'b0;
                        end
                    end
                    if (level_next)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    rise = !level_reg && level_next;
                    fall = level_reg && !level_next;

                    // advance at most one stage per master edge
                    unique case (step_reg)
                        STEP_WAIT:
                            if (rise)
                            begin
                                wait_left_next = wait_dec;
                                if (wait_dec == 8'd0)
                                begin
                                    prev_count_next = count_next;
                                    step_next       = STEP_SET_A0;
                                end
                            end
                        STEP_SET_A0:
                            if (rise)
                            begin
                                a0_next   = pend_kind_reg;
                                step_next = STEP_CS_LOW;
                            end
                        STEP_CS_LOW:
                            if (fall)
                            begin
                                cs_n_next = 1'b0;
                                step_next = STEP_SET_D;
                            end
                        STEP_SET_D:
                            if (rise)
                            begin
                                data_next = pend_byte_reg;
                                step_next = STEP_WR_LOW;
                            end
                        STEP_WR_LOW:
                            if (fall)
                            begin
                                wr_n_next = 1'b0;
                                step_next = STEP_HOLD;
                            end
                        STEP_HOLD:
                            if (rise)
                            begin
                                step_next = STEP_RELEASE;
                            end
                        STEP_RELEASE:
                            if (fall)
                            begin
                                wr_n_next = 1'b1;
                                cs_n_next = 1'b1;
                                step_next = STEP_CLEAR_D;
                            end
                        STEP_CLEAR_D:
                            if (rise)
                            begin
                                data_next = DATA_IDLE;
                                step_next = STEP_IDLE;
                            end
                        default:
                            step_next = STEP_IDLE;
                    endcase
                end
                OP_ADDR, OP_DATA:
                begin
                    if (step_reg == STEP_IDLE)
                    begin
                        accepted       = 1'b1;
                        pend_kind_next = (req.payload.opcode == OP_DATA);
                        pend_byte_next = req.payload.byte_value;
                        prev_kind_next = (req.payload.opcode == OP_DATA) ? KIND_DATA
                                                                          : KIND_ADDR;
                        if ((need != 8'd0) && (diff < COUNT_WIDTH'(need)))
                        begin
                            wait_left_next = need - diff[7:0];
                            step_next      = STEP_WAIT;
                        end
                        else
                        begin
                            wait_left_next  = 8'd0;
                            prev_count_next = count_reg;
                            step_next       = STEP_SET_A0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // result fields after this item
    always_comb
    begin
        out_item.address_select   = a0_next;
        out_item.chip_select_n    = cs_n_next;
        out_item.write_strobe_n   = wr_n_next;
        out_item.data_bus         = data_next;
        out_item.master_phase     = level_next;
        out_item.busy_res         = (step_next != STEP_IDLE);
        out_item.request_accepted = accepted;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= '0;
            level_reg      <= 1'b0;
            count_reg      <= '0;
            prev_kind_reg  <= KIND_NONE;
            prev_count_reg <= '0;
            wait_left_reg  <= 8'd0;
            step_reg       <= STEP_IDLE;
            pend_kind_reg  <= 1'b0;
            pend_byte_reg  <= 8'd0;
            a0_reg         <= 1'b0;
            cs_n_reg       <= 1'b1;
            wr_n_reg       <= 1'b1;
            data_reg       <= DATA_IDLE;
        end
        else
        begin
            phase_reg      <= phase_next;
            level_reg      <= level_next;
            count_reg      <= count_next;
            prev_kind_reg  <= prev_kind_next;
            prev_count_reg <= prev_count_next;
            wait_left_reg  <= wait_left_next;
            step_reg       <= step_next;
            pend_kind_reg  <= pend_kind_next;
            pend_byte_reg  <= pend_byte_next;
            a0_reg         <= a0_next;
            cs_n_reg       <= cs_n_next;
            wr_n_reg       <= wr_n_next;
            data_reg       <= data_next;
        end
    end

    // result register: load on an input transfer, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_item_reg <= out_item;
        end
    end

endmodule
